@@ rtl/core/scwt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scwt_pkg: shared types and constants of the sensor condition watch table
// Result codes, field widths and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package scwt_pkg;

  localparam int WORD_W   = 32;
  localparam int WAITER_W = 4;
  localparam int SLOT_W   = 3;

  localparam logic MODE_SUBSCRIBE = 1'b0;
  localparam logic MODE_SCAN      = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_FIRED   = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the request, start a walk
    logic step;     // process the slot under the walk index
    logic finish;   // close out the request
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scan;
    logic hit;         // current slot fires
    logic pend_valid;  // a fired result is held back for its last flag
    logic at_end;      // walk index on the final slot
    logic out_free;    // result register can take a new transfer
  } ctl_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/scwt_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scwt_req_if: request channel
// Subscribe or scan request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scwt_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] watch_mask;
  logic [31:0] watch_pattern;
  logic [3:0]  waiter_id;
  logic [31:0] sensor_word;

  modport source (output valid, mode, watch_mask, watch_pattern, waiter_id, sensor_word,
                  input ready);
  modport sink   (input valid, mode, watch_mask, watch_pattern, waiter_id, sensor_word,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/scwt_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scwt_rsp_if: result channel
// One result per transfer with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scwt_rsp_if;
  logic               valid;
  logic               ready;
  scwt_pkg::status_t  status;
  logic [3:0]         fired_waiter;
  logic [2:0]         slot;
  logic               last;

  modport source (output valid, status, fired_waiter, slot, last, input ready);
  modport sink   (input valid, status, fired_waiter, slot, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/scwt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scwt_ctrl: request sequencer
// Accepts a request, walks the table one slot per cycle unless stalled, then closes it out.
// ----------------------------------------------------------------------------
module scwt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  scwt_pkg::ctl_stat_t  stat,
  output scwt_pkg::ctl_cmd_t   cmd
);
  import scwt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;
  logic   stall;

  // a second hit cannot displace the held one until the result register drains
  always_comb begin
    stall = stat.hit && stat.pend_valid && !stat.out_free;
    cmd   = '0;
    case (state)
      S_IDLE:  cmd.capture = req_valid && req_ready;
      S_WALK:  cmd.step    = !stall;
      S_DONE:  cmd.finish  = stat.out_free || (stat.is_scan && !stat.pend_valid);
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state     <= S_WALK;
            req_ready <= 1'b0;
          end
        end
        S_WALK: begin
          if (cmd.step && stat.at_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.finish) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.step, cmd.finish}))
    else $error("controller issued overlapping commands");

  a_finish_reopens: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> req_ready && state == S_IDLE)
    else $error("request channel not reopened after finish");

  a_capture_closes: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !req_ready && state == S_WALK)
    else $error("request channel still open during walk");

endmodule
`default_nettype wire

@@ rtl/core/scwt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scwt_dp: watch table datapath
// Entry registers, walk index, subscribe bookkeeping, held fired result and
// the result register.
// ----------------------------------------------------------------------------
module scwt_dp #(
  parameter int TABLE_DEPTH = 8,
  parameter int WAITER_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  scwt_req_if.sink             req,
  scwt_rsp_if.source           rsp,
  input  scwt_pkg::ctl_cmd_t   cmd,
  output scwt_pkg::ctl_stat_t  stat
);
  import scwt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  // table
  logic [TABLE_DEPTH-1:0] valid;
  logic [WORD_W-1:0]      mask_q    [TABLE_DEPTH];
  logic [WORD_W-1:0]      pattern_q [TABLE_DEPTH];
  logic [WAITER_BITS-1:0] waiter_q  [TABLE_DEPTH];

  // latched request
  logic                   mode;
  logic [WORD_W-1:0]      key_mask;
  logic [WORD_W-1:0]      key_pattern;
  logic [WAITER_BITS-1:0] key_waiter;
  logic [WORD_W-1:0]      sensor;

  // walk
  logic [IDX_W-1:0]       idx;
  logic                   dup;
  logic                   free_found;
  logic [IDX_W-1:0]       free_slot;
  logic                   pend_valid;
  logic [IDX_W-1:0]       pend_slot;
  logic [WAITER_BITS-1:0] pend_waiter;

  // result register
  logic                   out_valid;
  status_t                out_status;
  logic [WAITER_W-1:0]    out_waiter;
  logic [SLOT_W-1:0]      out_slot;
  logic                   out_last;

  logic    cur_valid;
  logic    match_sub;
  logic    hit;
  logic    out_free;
  logic    store;
  logic    load_out;
  status_t sub_status;

  always_comb begin
    cur_valid = valid[idx];
    match_sub = cur_valid && (mask_q[idx] == key_mask) && (pattern_q[idx] == key_pattern);
    hit       = (mode == MODE_SCAN) && cur_valid &&
                ((sensor & mask_q[idx]) == pattern_q[idx]);
    out_free  = !out_valid || rsp.ready;
    if (key_mask == '0 || dup) begin
      sub_status = ST_DROPPED;
    end else if (free_found) begin
      sub_status = ST_STORED;
    end else begin
      sub_status = ST_FULL;
    end
    store    = cmd.finish && (mode == MODE_SUBSCRIBE) && (sub_status == ST_STORED);
    load_out = (cmd.step && hit && pend_valid) ||
               (cmd.finish && ((mode == MODE_SUBSCRIBE) || pend_valid));
  end

  assign stat.is_scan    = (mode == MODE_SCAN);
  assign stat.hit        = hit;
  assign stat.pend_valid = pend_valid;
  assign stat.at_end     = (idx == IDX_LAST);
  assign stat.out_free   = out_free;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.fired_waiter = out_waiter;
  assign rsp.slot         = out_slot;
  assign rsp.last         = out_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        pend_valid <= 1'b0;
      end
      if (cmd.step && hit) begin
        valid[idx] <= 1'b0;
        pend_valid <= 1'b1;
      end
      if (store) begin
        valid[free_slot] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode        <= req.mode;
      key_mask    <= req.watch_mask;
      key_pattern <= req.watch_pattern;
      key_waiter  <= WAITER_BITS'(req.waiter_id);
      sensor      <= req.sensor_word;
      idx         <= '0;
      dup         <= 1'b0;
      free_found  <= 1'b0;
    end
    if (cmd.step) begin
      if (idx != IDX_LAST) begin
        idx <= idx + 1'b1;
      end
      if (match_sub) begin
        dup <= 1'b1;
      end
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
      if (hit) begin
        pend_slot   <= idx;
        pend_waiter <= waiter_q[idx];
      end
    end
    if (store) begin
      mask_q[free_slot]    <= key_mask;
      pattern_q[free_slot] <= key_pattern;
      waiter_q[free_slot]  <= key_waiter;
    end
    if (load_out) begin
      if (cmd.step || mode == MODE_SCAN) begin
        out_status <= ST_FIRED;
        out_waiter <= WAITER_W'(pend_waiter);
        out_slot   <= SLOT_W'(pend_slot);
        out_last   <= cmd.finish;
      end else begin
        out_status <= sub_status;
        out_waiter <= '0;
        out_slot   <= store ? SLOT_W'(free_slot) : '0;
        out_last   <= 1'b1;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result register overwritten before transfer");

  a_sub_no_waiter: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_FIRED |-> rsp.fired_waiter == '0)
    else $error("subscribe result carries a waiter id");

  a_store_sets_valid: assert property (@(posedge clk) disable iff (rst)
    store |=> valid[$past(free_slot)])
    else $error("stored entry not marked valid");

endmodule
`default_nettype wire

@@ rtl/core/sensor_condition_watch_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_condition_watch_table_core: table of pending sensor watch conditions
// Subscribe stores a mask/pattern/waiter entry in the lowest free slot unless
// it duplicates a valid entry or has a zero mask. Scan fires and clears every
// valid entry whose masked sensor bits equal its pattern, lowest slot first.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ----------------------------------------------
//  req      in   valid / ready  mode, watch_mask, watch_pattern, waiter_id,
//                               sensor_word
//  rsp      out  valid / ready  status, fired_waiter, slot, last
//
// Sequence: one request at a time. Capture, then the table walk (one slot
// per cycle through the entry registers, unless the walk stalls), then the
// close-out. Subscribe gives exactly one result; scan gives one per fired
// entry, the final one flagged by last, and none when nothing fires.
// Reset: synchronous rst clears all entry valid bits and the result register.
// Stalls: one fired result is held back to learn its last flag; the walk stops
// on a further hit while the result register is still occupied. A new request
// can be accepted while the final result still waits for its transfer.
// ----------------------------------------------------------------------------
module sensor_condition_watch_table_core #(
  parameter int TABLE_DEPTH = 8,
  parameter int WAITER_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  scwt_req_if.sink    req,
  scwt_rsp_if.source  rsp
);
  import scwt_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      ready;

  assign req.ready = ready;

  scwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scwt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WAITER_BITS (WAITER_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
`default_nettype wire
